FILE: sv/cipd_pkg.sv
// Package for the case-insensitive pattern deleter.
// Holds widths, register indexes and the ASCII case fold; no dependencies.
package cipd_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned PatBytes      = 16;
  localparam int unsigned PatIdxW       = 4;
  localparam int unsigned LenRegW       = 5;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 64;

  localparam logic [CharW-1:0] SpaceChar = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLen  = 2'd0,
    RegPatternLow  = 2'd1,
    RegPatternHigh = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctrl_t;

  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/cipd_cell.sv
// One window cell of the pattern deleter: holds a character, passes it on.
// Depends on cipd_pkg for the case fold and the control struct.
module cipd_cell (
  input  logic                          clk_i,
  input  cipd_pkg::cell_ctrl_t          ctrl_i,
  input  logic [cipd_pkg::CharW-1:0]    char_i,
  input  logic [cipd_pkg::CharW-1:0]    pat_char_i,
  output logic [cipd_pkg::CharW-1:0]    char_o,
  output logic                          eq_o
);
  import cipd_pkg::*;

  logic [CharW-1:0] char_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      char_q <= char_i;
    end
  end

  assign char_o = char_q;
  assign eq_o   = !ctrl_i.active || (fold(char_q) == fold(pat_char_i));

endmodule

FILE: sv/case_insensitive_pattern_deleter.sv
// Top level of the case-insensitive pattern deleter: a row of window cells,
// match logic, line-end flush and output register. Depends on cipd_pkg, cipd_cell.
//
//   channel   dir  payload                               accepted when
//   s_axis    in   tdata[7:0] in_char, tlast end_of_line  tvalid & tready
//   m_axis    out  tdata[7:0] out_char, tuser has_char,   tvalid & tready
//                  tlast line_done
//   cfg       in   cfg_idx_i register, cfg_data_i value   cfg_we_i
//
// One request per cycle while s_axis_tready is high; results leave through the output register.
// A final character with r characters left in the window holds s_axis until they
// are flushed (r up to pattern length - 1), one per cycle while m_axis is free.
// Reset clears the window fill, the drop and flush flags and the output valid bit.
// m_axis stall holds the output register and drops s_axis_tready.
module case_insensitive_pattern_deleter #(
  parameter int unsigned MaxPattern = cipd_pkg::MaxPatternDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] in_char
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] out_char
  output logic                            m_axis_tuser,  // [0] has_char
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [cipd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cipd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import cipd_pkg::*;

  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  logic [LenRegW-1:0]        pat_len_q;
  logic [2*CfgDataW-1:0]     pat_q;
  logic [CharW-1:0]          pat_byte [PatBytes];

  logic [IdxW-1:0]           fill_q, fill_d;
  logic                      drop_q, drop_d;
  logic                      flush_q, flush_d;
  logic                      out_valid_q, out_valid_d;
  logic [CharW-1:0]          out_char_q, out_char_d;
  logic                      out_has_q, out_has_d;
  logic                      out_done_q, out_done_d;

  logic [LenW-1:0]           len;
  logic [LenW-1:0]           fill_plus;
  logic [CharW-1:0]          cell_char [MaxPattern];
  logic [MaxPattern-1:0]     cell_eq;
  cell_ctrl_t                cell_ctrl [MaxPattern];
  logic                      out_free, accept, drop_sp, full, match, ch_eq, shift;
  logic [CharW-1:0]          rd_char, emit_char;
  logic [PatIdxW-1:0]        ch_pat_idx;

  for (genvar k = 0; k < PatBytes; k++) begin : g_pat
    assign pat_byte[k] = pat_q[CharW*k +: CharW];
  end

  always_comb begin
    if (pat_len_q == '0) begin
      len = LenW'(1);
    end else if (pat_len_q > LenRegW'(MaxPattern)) begin
      len = LenW'(MaxPattern);
    end else begin
      len = LenW'(pat_len_q);
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !flush_q && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign drop_sp       = drop_q && (s_axis_tdata == SpaceChar);
  assign shift         = accept && !drop_sp;
  assign fill_plus     = LenW'(fill_q) + LenW'(1);
  assign full          = (fill_plus == len);
  assign ch_pat_idx    = PatIdxW'(len) - PatIdxW'(1);
  assign ch_eq         = fold(s_axis_tdata) == fold(pat_byte[ch_pat_idx]);
  assign match         = ch_eq && (&cell_eq);
  assign rd_char       = cell_char[fill_q - IdxW'(1)];
  assign emit_char     = (fill_q == '0) ? s_axis_tdata : rd_char;

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic [PatIdxW-1:0] pat_idx;
    logic [CharW-1:0]   char_in;

    assign pat_idx            = PatIdxW'(len) - PatIdxW'(j + 2);
    assign cell_ctrl[j].shift = shift;
    assign cell_ctrl[j].active = {1'b0, len} >= (LenW + 1)'(j + 2);

    if (j == 0) begin : g_head
      assign char_in = s_axis_tdata;
    end else begin : g_link
      assign char_in = cell_char[j-1];
    end

    cipd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[j]),
      .char_i     (char_in),
      .pat_char_i (pat_byte[pat_idx]),
      .char_o     (cell_char[j]),
      .eq_o       (cell_eq[j])
    );
  end

  always_comb begin
    logic             emit;
    logic [IdxW-1:0]  post_fill;

    fill_d      = fill_q;
    drop_d      = drop_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_has_d   = out_has_q;
    out_done_d  = out_done_q;
    emit        = 1'b0;
    post_fill   = fill_q;

    if (accept) begin
      drop_d = 1'b0;
      if (!drop_sp) begin
        if (!full) begin
          post_fill = IdxW'(fill_plus);
        end else if (match) begin
          post_fill = '0;
          drop_d    = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      fill_d = post_fill;
      if (s_axis_tlast) begin
        drop_d = 1'b0;
        if (post_fill == '0) begin
          out_valid_d = 1'b1;
          out_char_d  = emit ? emit_char : '0;
          out_has_d   = emit;
          out_done_d  = 1'b1;
        end else begin
          flush_d = 1'b1;
          if (emit) begin
            out_valid_d = 1'b1;
            out_char_d  = emit_char;
            out_has_d   = 1'b1;
            out_done_d  = 1'b0;
          end
        end
      end else if (emit) begin
        out_valid_d = 1'b1;
        out_char_d  = emit_char;
        out_has_d   = 1'b1;
        out_done_d  = 1'b0;
      end
    end else if (flush_q && out_free) begin
      out_valid_d = 1'b1;
      out_char_d  = rd_char;
      out_has_d   = 1'b1;
      out_done_d  = (fill_q == IdxW'(1));
      fill_d      = fill_q - IdxW'(1);
      if (fill_q == IdxW'(1)) begin
        flush_d = 1'b0;
      end
    end

    if (cfg_we_i && (cfg_idx_i == RegPatternLen)) begin
      fill_d  = '0;
      drop_d  = 1'b0;
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= LenRegW'(1);
      pat_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPatternLen:  pat_len_q <= cfg_data_i[LenRegW-1:0];
        RegPatternLow:  pat_q[CfgDataW-1:0] <= cfg_data_i;
        RegPatternHigh: pat_q[2*CfgDataW-1:CfgDataW] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drop_q      <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_has_q  <= out_has_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_done_q;

endmodule
